/* rtl/core/vmavg_pkg.sv */
// shared constants, types and state codes for the moving average block
`timescale 1ns / 1ps

package vmavg_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 8;

    // default store depth and register reset value
    localparam int          WINDOW_MAX_DEF   = 128;
    localparam logic [7:0]  WINDOW_LEN_RESET = 8'd15;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START,
        ST_DIVIDE,
        ST_WRITE
    } vmavg_state_t;

    // per-cycle command shared by every cell of the history chain
    typedef struct packed {
        logic shift;   // take the lower neighbour (new sample enters cell 0)
        logic rotate;  // take the upper neighbour (cell 0 wraps to the top)
    } cell_ctrl_t;

endpackage

/* rtl/core/vmavg_cell.sv */
// one history cell: holds a sample, shifts up on a new beat or rotates down
`timescale 1ns / 1ps

module vmavg_cell
    import vmavg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] shift_in,
    input  logic signed [SAMPLE_W-1:0] rot_in,
    output logic signed [SAMPLE_W-1:0] value
);

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;

    // select the neighbour to take this cycle
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = shift_in;
        end
        else if (ctrl.rotate)
        begin
            value_next = rot_in;
        end
    end

    // history starts out as zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

/* rtl/core/vmavg_div.sv */
// signed sum by unsigned count, one quotient bit per cycle, truncated toward zero
`timescale 1ns / 1ps

module vmavg_div
    import vmavg_pkg::*;
#(
    parameter int SUM_W = 23,
    parameter int DIV_W = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       busy,
    output logic signed [SAMPLE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             neg_reg;
    logic             neg_next;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] den_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [SUM_W-1:0] quo_reg;
    logic [SUM_W-1:0] quo_next;
    logic [DIV_W:0]   partial;
    logic [DIV_W:0]   diff;
    logic [SUM_W-1:0] quo_signed;

    // one restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        partial   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = partial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[SUM_W-1];
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // restore the sign of the magnitude quotient
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[SAMPLE_W-1:0];
    assign busy       = busy_reg;

endmodule

/* rtl/core/variable_window_moving_average.sv */
// top level: history chain of cells, serial accumulator and bit-serial divider
`timescale 1ns / 1ps

// Moving average over the newest window_len samples, truncated toward zero.
// The history is a chain of WINDOW_MAX cells, zeroed by reset. An accepted
// beat shifts the new sample into the chain; the chain then rotates once
// through all WINDOW_MAX cells while the accumulator adds the newest
// window_len entries, then the divider produces one quotient bit per cycle.
// A new sample is taken only in the idle state, after the divider has
// finished and the average has entered the output register. A finished
// average waits in the output register while the next sample is taken.
// window_len of zero acts as one and values above WINDOW_MAX act as
// WINDOW_MAX; write it only when idle.
module variable_window_moving_average
    import vmavg_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] average
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data   // window_len
);

    localparam int NW    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);

    vmavg_state_t               state_reg;
    vmavg_state_t               state_next;
    logic [CFG_W-1:0]           win_reg;
    logic [NW-1:0]              n_reg;
    logic [NW-1:0]              n_next;
    logic [NW-1:0]              cnt_reg;
    logic [NW-1:0]              cnt_next;
    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SUM_W-1:0]    acc_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic [SAMPLE_W-1:0]        m_data_next;
    logic                       accept;
    logic                       div_start;
    logic                       div_busy;
    logic signed [SAMPLE_W-1:0] div_quo;
    logic [NW-1:0]              n_eff;
    cell_ctrl_t                 cell_ctrl;
    logic signed [SAMPLE_W-1:0] cell_val [WINDOW_MAX];

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            win_reg <= cfg_data;
        end
    end

    // clamp the window to one .. WINDOW_MAX
    always_comb
    begin
        if (win_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(win_reg) > WINDOW_MAX)
        begin
            n_eff = NW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = NW'(win_reg);
        end
    end

    // chain of history cells
    assign cell_ctrl.shift  = accept;
    assign cell_ctrl.rotate = (state_reg == ST_ACCUM);

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] lower;
        logic signed [SAMPLE_W-1:0] upper;
        if (i == 0)
        begin : g_first
            assign lower = s_tdata;
        end
        else
        begin : g_mid_lo
            assign lower = cell_val[i-1];
        end
        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign upper = cell_val[0];
        end
        else
        begin : g_mid_hi
            assign upper = cell_val[i+1];
        end
        vmavg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (lower),
            .rot_in   (upper),
            .value    (cell_val[i])
        );
    end

    // bit-serial divider
    vmavg_div #(
        .SUM_W (SUM_W),
        .DIV_W (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (n_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // sequencer, accumulator and output register
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = n_eff;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                // cell 0 shows the entry cnt_reg places from the newest
                if (cnt_reg < n_reg)
                begin
                    acc_next = acc_reg + SUM_W'(cell_val[0]);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NW'(WINDOW_MAX - 1))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = div_quo;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a new result only appears out of the write state
    a_valid_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared outside write state");

    // the divider is quiet whenever a new sample may be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // the latched window stays within one .. WINDOW_MAX during the sum
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> (n_reg != '0 && 32'(n_reg) <= WINDOW_MAX))
        else $error("window out of range");

    // the rotation count never passes the chain length
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> (32'(cnt_reg) < WINDOW_MAX))
        else $error("rotation count overrun");

    // the sum is handed over exactly when the rotation ends
    a_start_after_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |-> $past(state_reg == ST_ACCUM))
        else $error("divider started out of order");

endmodule

/* bench/variable_window_moving_average_test.sv */
// self-checking stream testbench for the variable window moving average block
`timescale 1ns / 1ps

module variable_window_moving_average_test;

    import vmavg_pkg::*;

    localparam int WINDOW_MAX   = WINDOW_MAX_DEF;
    // one item: full chain rotation, divider and sequencing
    localparam int ITEM_CYCLES  = WINDOW_MAX + 16 + $clog2(WINDOW_MAX) + 4;
    localparam int GAP_MAX      = 18;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 75;
    localparam int CYCLE_LIMIT  = 800000;

    // how the random samples of one phase are drawn
    typedef enum int {
        MIX_FULL,
        RUN_EXTREME,
        NEAR_ZERO
    } sample_mix_t;

    // running model of the history store and the expected averages
    class avg_scoreboard;
        logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
        logic [CFG_W-1:0]           window_len;
        logic [SAMPLE_W-1:0]        expected_avg [$];
        int                         errors;
        int                         noted;
        int                         checked;

        function new();
            foreach (history[i])
                history[i] = '0;
            window_len = WINDOW_LEN_RESET;
            errors     = 0;
            noted      = 0;
            checked    = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            window_len = value;
        endfunction

        function int pending();
            return expected_avg.size();
        endfunction

        // shift in the accepted sample and queue the average it yields
        function void note_sample(logic [SAMPLE_W-1:0] raw);
            int     span;
            longint sum;
            // zero acts as one, oversize saturates to the store depth
            if (window_len == 0)
                span = 1;
            else if (window_len > WINDOW_MAX)
                span = WINDOW_MAX;
            else
                span = window_len;
            for (int i = WINDOW_MAX - 1; i > 0; i--)
                history[i] = history[i - 1];
            history[0] = raw;
            sum = 0;
            for (int i = 0; i < span; i++)
                sum += longint'(history[i]);
            // longint division truncates toward zero
            expected_avg.push_back(SAMPLE_W'(sum / longint'(span)));
            noted++;
        endfunction

        // compare one output beat with the oldest expectation
        function void check_average(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] want;
            if (expected_avg.size() == 0)
            begin
                $error("average: beat with nothing expected, expected none actual %0d",
                       $signed(actual));
                errors++;
            end
            else
            begin
                want = expected_avg.pop_front();
                checked++;
                if (want !== actual)
                begin
                    $error("average: expected %0d actual %0d", $signed(want),
                           $signed(actual));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    avg_scoreboard       sb;
    bit                  no_idle   = 1'b0;
    bit                  long_hold = 1'b0;
    int                  window_writes = 0;
    int                  cycle_count   = 0;

    variable_window_moving_average #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] average
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // window_len
    );

    // free-running clock, 20 ns period
    always #10 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // input and output beat monitors
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_sample(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_average(m_tdata);
    end

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [15:0] pick_sample(sample_mix_t mix, logic [15:0] run_value);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            RUN_EXTREME: return (roll < 90) ? run_value : 16'($urandom);
            NEAR_ZERO:   return (roll < 85) ? 16'($urandom_range(0, 8) - 4) : 16'($urandom);
            default:
            begin
                if (roll < 15)
                    return 16'h7fff;
                else if (roll < 30)
                    return 16'h8000;
                else
                    return 16'($urandom);
            end
        endcase
    endfunction

    // offer one sample after a random gap, return once it is taken
    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    // drain the block, then write window_len
    task automatic write_window(input logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted beat first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_window(value);
        window_writes++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // main sequence
    initial
    begin
        logic [CFG_W-1:0] win;
        logic [15:0]      run_value;
        sample_mix_t      mix;

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window, zeroed history, field extremes
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);

        // single sample window
        write_window(8'd1);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'hffff);

        // zero window behaves as one
        write_window(8'd0);
        send_sample(16'h1234);
        send_sample(16'hfffd);

        // full depth window, negative sum truncated toward zero
        write_window(8'(WINDOW_MAX));
        send_sample(16'hffff);
        send_sample(16'h8000);
        send_sample(16'h7fff);

        // oversized windows saturate to full depth
        write_window(8'hff);
        send_sample(16'h8000);
        send_sample(16'h0003);
        write_window(8'(WINDOW_MAX + 1));
        send_sample(16'hfffe);
        send_sample(16'h7fff);

        // random phases over several window settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       win = 8'd2;
                1:       win = 8'(WINDOW_MAX);
                2:       win = 8'd3;
                3:       win = 8'd15;
                4:       win = 8'(WINDOW_MAX - 1);
                5:       win = 8'd1;
                6:       win = 8'($urandom_range(129, 255));
                default: win = 8'($urandom_range(0, 255));
            endcase
            write_window(win);
            mix       = sample_mix_t'(p % 3);
            run_value = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            no_idle   = (p == 3 || p == 7);
            // long receiver hold while the sender keeps offering
            if (p == 3)
                long_hold = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample(mix, run_value));
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then watch for stray beats
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (ITEM_CYCLES + 32) @(posedge clk);

        $display("run: %0d samples sent, %0d averages checked", sb.noted, sb.checked);
        $display("run: %0d window_len writes incl. zero, full depth and oversize",
                 window_writes);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
